@@ rtl/mfr_pkg.sv @@
`default_nettype none
package mfr_pkg;

   localparam int BUFFER_BYTES_DEF   = 48;
   localparam int PREAMBLE_BYTES_DEF = 10;

   localparam logic [1:0] OP_BYTE  = 2'd0;
   localparam logic [1:0] OP_POLL  = 2'd1;
   localparam logic [1:0] OP_WDOG  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_WDOG   = 2'd1;
   localparam logic [1:0] KIND_FWD    = 2'd2;

   localparam logic [1:0] CSR_FRAME_HEAD   = 2'd0;
   localparam logic [1:0] CSR_POLL_LIMIT   = 2'd1;
   localparam logic [1:0] CSR_DATA_TIMEOUT = 2'd2;

   localparam logic [7:0] PASS_CODE     = 8'hAB;
   localparam logic [7:0] PREAMBLE_FILL = 8'hFE;
   localparam int         MIN_FRAME     = 22;
   localparam int         LEN_OVERHEAD  = 3;
   localparam int         DEC_FIRST     = 2;
   localparam int         DEC_LAST      = 19;
   localparam int         DEC_BYTES     = DEC_LAST - DEC_FIRST + 1;
   localparam logic [7:0] ERR_REVERSE   = 8'h08;
   localparam logic [7:0] ERR_TEMP      = 8'h10;
   localparam logic [7:0] ERR_PRESSURE  = 8'h20;

   typedef enum logic [1:0] {CMD_BYTE, CMD_POLL, CMD_WDOG} cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_entry_type;

   typedef struct packed {
      logic [7:0] frame_head;
      logic [7:0] poll_limit;
      logic [7:0] data_timeout;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_B1, ST_SUM, ST_DEC, ST_COMMIT, ST_PRE, ST_FWD, ST_EMIT
   } back_state_type;

endpackage
`default_nettype wire

@@ rtl/mfr_ram.sv @@
`default_nettype none
module mfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ rtl/mfr_front.sv @@
`default_nettype none
module mfr_front
   import mfr_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [1:0]    req_operation,
   input  wire logic [7:0]    req_rx_byte,
   output logic               cmd_valid,
   output cmd_entry_type      cmd,
   input  wire logic          cmd_take
);
   cmd_entry_type q_ff [0:1];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       keep;
   logic       wr;
   cmd_entry_type ent;

   assign full      = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      keep      = 1'b1;
      ent.data  = req_rx_byte;
      ent.kind  = CMD_BYTE;
      unique case (req_operation)
         OP_BYTE: ent.kind = CMD_BYTE;
         OP_POLL: ent.kind = CMD_POLL;
         OP_WDOG: ent.kind = CMD_WDOG;
         default: keep = 1'b0;  // drop unused operation code
      endcase
      wr     = push && !full && keep;
      wp_in  = wr ? !wp_ff : wp_ff;
      rp_in  = cmd_take ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, wr} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (wr) begin
         q_ff[wp_ff] <= ent;
      end
   end
endmodule
`default_nettype wire

@@ rtl/mfr_back.sv @@
`default_nettype none
module mfr_back
   import mfr_pkg::*;
#(
   parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
   parameter int PREAMBLE_BYTES = PREAMBLE_BYTES_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          cmd_valid,
   input  wire cmd_entry_type cmd,
   output logic               cmd_take,
   output logic               empty,
   input  wire logic          pop,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last,
   output logic [31:0]        rsp_flow_rate,
   output logic [31:0]        rsp_volume,
   output logic [15:0]        rsp_temperature,
   output logic [15:0]        rsp_pressure,
   output logic [7:0]         rsp_direction,
   output logic [7:0]         rsp_meter_type,
   output logic [7:0]         rsp_error_flags,
   output logic               rsp_measure_error,
   output logic               rsp_inspection_mode
);
   localparam int LW = $clog2(BUFFER_BYTES);
   localparam int PW = (PREAMBLE_BYTES > 1) ? $clog2(PREAMBLE_BYTES) : 1;

   back_state_type st_ff, st_in;
   logic [LW-1:0] len_ff, len_in, ptr_ff, ptr_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic [7:0]    head_ff, head_in, pc_ff, pc_in, wd_ff, wd_in, sum_ff, sum_in;
   logic          sess_ff, sess_in, bsp_ff, bsp_in;
   logic [31:0]   flow_ff, flow_in, vol_ff, vol_in;
   logic [15:0]   temp_ff, temp_in, pres_ff, pres_in;
   logic [7:0]    dir_ff, dir_in, type_ff, type_in, err_ff, err_in;
   logic          me_ff, me_in, insp_ff, insp_in;
   logic [1:0]    ek_ff, ek_in;
   logic [7:0]    sh_ff [0:DEC_BYTES-1];
   logic          shift;

   logic          ram_we;
   logic [LW-1:0] ram_waddr, len_eff;
   logic [7:0]    ram_q, byte0;

   logic          out_vld_ff, out_free, load;
   logic [1:0]    ld_kind;
   logic [7:0]    ld_byte;
   logic          ld_last;

   mfr_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (cmd.data),
      .raddr (ptr_in),
      .rdata (ram_q)
   );

   assign out_free = !out_vld_ff || pop;
   assign empty    = !out_vld_ff;

   always_comb begin
      st_in = st_ff;  len_in = len_ff;  ptr_in = ptr_ff;  cnt_in = cnt_ff;
      head_in = head_ff;  pc_in = pc_ff;  wd_in = wd_ff;  sum_in = sum_ff;
      sess_in = sess_ff;  bsp_in = bsp_ff;  flow_in = flow_ff;  vol_in = vol_ff;
      temp_in = temp_ff;  pres_in = pres_ff;  dir_in = dir_ff;  type_in = type_ff;
      err_in = err_ff;  me_in = me_ff;  insp_in = insp_ff;  ek_in = ek_ff;
      cmd_take = 1'b0;  ram_we = 1'b0;  ram_waddr = len_ff;  len_eff = len_ff;
      byte0 = head_ff;  shift = 1'b0;
      load = 1'b0;  ld_kind = KIND_STATUS;  ld_byte = 8'h00;  ld_last = 1'b1;
      unique case (st_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               unique case (cmd.kind)
                  CMD_BYTE: begin
                     if (!sess_ff) begin
                        len_eff = '0;
                        pc_in   = 8'd0;
                        sess_in = 1'b1;
                     end
                     ram_we    = 1'b1;
                     ram_waddr = len_eff;
                     byte0     = (len_eff == '0) ? cmd.data : head_ff;
                     head_in   = byte0;
                     len_in    = len_eff;
                     if (byte0 == cfg.frame_head) begin
                        len_in = (len_eff == LW'(BUFFER_BYTES - 1)) ? '0 : len_eff + 1'b1;
                     end
                     bsp_in = 1'b1;
                  end
                  CMD_POLL: begin
                     if (sess_ff) begin
                        if (pc_ff >= cfg.poll_limit) begin
                           len_in = '0;  pc_in = 8'd0;  sess_in = 1'b0;
                        end else if (head_ff == cfg.frame_head && len_ff != '0) begin
                           if (!bsp_ff) begin
                              if (7'(len_ff) < 7'(MIN_FRAME)) begin
                                 len_in = '0;  pc_in = 8'd0;  sess_in = 1'b0;
                              end else begin
                                 ptr_in = LW'(1);
                                 st_in  = ST_B1;
                              end
                           end else begin
                              bsp_in = 1'b0;
                              pc_in  = pc_ff + 8'd1;
                           end
                        end else begin
                           len_in = '0;
                           pc_in  = pc_ff + 8'd1;
                        end
                     end
                  end
                  CMD_WDOG: begin
                     if (wd_ff < cfg.data_timeout) begin
                        wd_in = wd_ff + 8'd1;
                        if (wd_ff + 8'd1 >= 8'd2) begin
                           flow_in = 32'd0;
                        end
                     end else begin
                        me_in = 1'b1;
                     end
                     ek_in = KIND_WDOG;
                     st_in = ST_EMIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_B1: begin
            // ram_q holds byte 1 here
            if (ram_q == PASS_CODE) begin
               ptr_in = '0;
               cnt_in = '0;
               st_in  = (PREAMBLE_BYTES == 0) ? ST_FWD : ST_PRE;
            end else if (9'(len_ff) == 9'(ram_q) + 9'(LEN_OVERHEAD)) begin
               sum_in = 8'd0;
               st_in  = ST_SUM;
            end else begin
               len_in = '0;  pc_in = 8'd0;  sess_in = 1'b0;
               st_in  = ST_IDLE;
            end
         end
         ST_SUM: begin
            if (ptr_ff == len_ff - LW'(2)) begin
               if (sum_ff == ram_q) begin
                  ptr_in = LW'(DEC_FIRST);
                  st_in  = ST_DEC;
               end else begin
                  len_in = '0;  pc_in = 8'd0;  sess_in = 1'b0;
                  st_in  = ST_IDLE;
               end
            end else begin
               sum_in = sum_ff + ram_q;
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_DEC: begin
            shift = 1'b1;
            if (ptr_ff == LW'(DEC_LAST)) begin
               st_in = ST_COMMIT;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_COMMIT: begin
            // shift line holds bytes 2..19 in order
            if (sh_ff[11] == 8'd0) begin
               temp_in = {sh_ff[9], sh_ff[10]};
            end
            if (sh_ff[14] == 8'd0) begin
               pres_in = {sh_ff[12], sh_ff[13]};
            end
            flow_in = {sh_ff[0], sh_ff[1], sh_ff[2], sh_ff[3]};
            vol_in  = {sh_ff[4], sh_ff[5], sh_ff[6], sh_ff[7]};
            dir_in  = sh_ff[16];
            type_in = sh_ff[15];
            insp_in = (sh_ff[8] != 8'd0);
            err_in  = err_ff | sh_ff[17]
                    | ((sh_ff[16] == 8'd0) ? ERR_REVERSE : 8'h00)
                    | ((sh_ff[11] != 8'd0) ? ERR_TEMP : 8'h00)
                    | ((sh_ff[14] != 8'd0) ? ERR_PRESSURE : 8'h00);
            me_in   = 1'b0;
            wd_in   = 8'd0;
            len_in  = '0;  pc_in = 8'd0;  sess_in = 1'b0;
            ek_in   = KIND_STATUS;
            st_in   = ST_EMIT;
         end
         ST_PRE: begin
            if (out_free) begin
               load    = 1'b1;
               ld_kind = KIND_FWD;
               ld_byte = PREAMBLE_FILL;
               ld_last = 1'b0;
               if (cnt_ff == PW'(PREAMBLE_BYTES - 1)) begin
                  st_in = ST_FWD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_FWD: begin
            if (out_free) begin
               load    = 1'b1;
               ld_kind = KIND_FWD;
               ld_byte = ram_q;
               ld_last = (ptr_ff == len_ff - LW'(1));
               if (ld_last) begin
                  len_in = '0;  pc_in = 8'd0;  sess_in = 1'b0;
                  st_in  = ST_IDLE;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load    = 1'b1;
               ld_kind = ek_ff;
               st_in   = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;  len_ff <= '0;  ptr_ff <= '0;  cnt_ff <= '0;
         head_ff <= 8'd0;  pc_ff <= 8'd0;  wd_ff <= 8'd0;  sum_ff <= 8'd0;
         sess_ff <= 1'b0;  bsp_ff <= 1'b0;  flow_ff <= 32'd0;  vol_ff <= 32'd0;
         temp_ff <= 16'd0;  pres_ff <= 16'd0;  dir_ff <= 8'd1;  type_ff <= 8'd0;
         err_ff <= 8'd0;  me_ff <= 1'b1;  insp_ff <= 1'b0;  ek_ff <= KIND_STATUS;
         out_vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in;  len_ff <= len_in;  ptr_ff <= ptr_in;  cnt_ff <= cnt_in;
         head_ff <= head_in;  pc_ff <= pc_in;  wd_ff <= wd_in;  sum_ff <= sum_in;
         sess_ff <= sess_in;  bsp_ff <= bsp_in;  flow_ff <= flow_in;  vol_ff <= vol_in;
         temp_ff <= temp_in;  pres_ff <= pres_in;  dir_ff <= dir_in;  type_ff <= type_in;
         err_ff <= err_in;  me_ff <= me_in;  insp_ff <= insp_in;  ek_ff <= ek_in;
         if (load) begin
            out_vld_ff <= 1'b1;
         end else if (pop) begin
            out_vld_ff <= 1'b0;
         end
      end
      if (shift) begin
         for (int i = 0; i < DEC_BYTES - 1; i++) begin
            sh_ff[i] <= sh_ff[i+1];
         end
         sh_ff[DEC_BYTES-1] <= ram_q;
      end
      if (load) begin
         rsp_kind            <= ld_kind;
         rsp_out_byte        <= ld_byte;
         rsp_last            <= ld_last;
         rsp_flow_rate       <= flow_ff;
         rsp_volume          <= vol_ff;
         rsp_temperature     <= temp_ff;
         rsp_pressure        <= pres_ff;
         rsp_direction       <= dir_ff;
         rsp_meter_type      <= type_ff;
         rsp_error_flags     <= err_ff;
         rsp_measure_error   <= me_ff;
         rsp_inspection_mode <= insp_ff;
      end
   end
endmodule
`default_nettype wire

@@ rtl/meter_frame_receiver.sv @@
// A byte word passes through the command queue and is then written to the frame buffer; a
// watchdog word passes through the queue and the watchdog update to ST_EMIT; a poll that
// checks a frame walks ST_B1, ST_SUM, ST_DEC and ST_COMMIT to ST_EMIT; a forwarded frame
// walks ST_B1, ST_PRE and ST_FWD, one result word a cycle while the output word is free.
// Throughput: set by the single frame buffer port, one byte per cycle unless output is held.
// Reset: synchronous, active high; clears the command queue, the output word
// and all frame and status state; no clearing pass is needed.
`default_nettype none
module meter_frame_receiver
   import mfr_pkg::*;
#(
   parameter int BUFFER_BYTES   = BUFFER_BYTES_DEF,
   parameter int PREAMBLE_BYTES = PREAMBLE_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_operation,
   input  wire logic [7:0]  req_rx_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic [31:0]      rsp_flow_rate,
   output logic [31:0]      rsp_volume,
   output logic [15:0]      rsp_temperature,
   output logic [15:0]      rsp_pressure,
   output logic [7:0]       rsp_direction,
   output logic [7:0]       rsp_meter_type,
   output logic [7:0]       rsp_error_flags,
   output logic             rsp_measure_error,
   output logic             rsp_inspection_mode,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_wdata
);
   cfg_type       cfg_ff;
   logic          cmd_valid, cmd_take;
   cmd_entry_type cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_head   <= 8'd0;
         cfg_ff.poll_limit   <= 8'd100;
         cfg_ff.data_timeout <= 8'd20;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_HEAD:   cfg_ff.frame_head   <= csr_wdata;
            CSR_POLL_LIMIT:   cfg_ff.poll_limit   <= csr_wdata;
            CSR_DATA_TIMEOUT: cfg_ff.data_timeout <= csr_wdata;
            default: ;
         endcase
      end
   end

   mfr_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   mfr_back #(
      .BUFFER_BYTES   (BUFFER_BYTES),
      .PREAMBLE_BYTES (PREAMBLE_BYTES)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_take            (cmd_take),
      .empty               (empty),
      .pop                 (pop),
      .rsp_kind            (rsp_kind),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_last            (rsp_last),
      .rsp_flow_rate       (rsp_flow_rate),
      .rsp_volume          (rsp_volume),
      .rsp_temperature     (rsp_temperature),
      .rsp_pressure        (rsp_pressure),
      .rsp_direction       (rsp_direction),
      .rsp_meter_type      (rsp_meter_type),
      .rsp_error_flags     (rsp_error_flags),
      .rsp_measure_error   (rsp_measure_error),
      .rsp_inspection_mode (rsp_inspection_mode)
   );
endmodule
`default_nettype wire
